/* sv/ffca_pkg.sv */
// Shared types and constants for the first-fit coalescing allocator.
// No dependencies; every other file but ffca_ram imports this package.
package ffca_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 33;

  localparam logic [CFG_IDX_W-1:0] CFG_ARENA_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ARENA_END  = 1'b1;

  localparam logic [CFG_DATA_W-1:0] ARENA_END_RST = 33'h0_0200_0000;

  localparam int unsigned MIN_SPLIT_BYTES = 32;
  localparam int unsigned MIN_SPLIT_GRAN  = MIN_SPLIT_BYTES / 16;

  // granule count of a request: ceil(n/16)+1 fits in 29 bits
  localparam int unsigned NEED_W = 29;

  typedef enum logic [1:0] {
    REQ_ALLOC,
    REQ_FREE,
    REQ_RESIZE,
    REQ_NOP
  } req_e;

  typedef enum logic [1:0] {
    ST_DONE,
    ST_NULL,
    ST_FAIL
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_START,
    S_SETUP,
    S_DISP,
    S_A_RD,
    S_A_CHK,
    S_A_FIN,
    S_R_RD,
    S_R_CHK,
    S_R_DEC,
    S_R_SHR2,
    S_F_INIT,
    S_F_RD,
    S_F_WT,
    S_F_W1,
    S_F_W2,
    S_F_W3,
    S_F_W4,
    S_RESP
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_SETUP,
    OP_DISP,
    OP_A_RD,
    OP_A_CHK,
    OP_A_FIN,
    OP_R_RD,
    OP_R_CHK,
    OP_R_DEC,
    OP_R_SHR2,
    OP_F_INIT,
    OP_F_RD,
    OP_F_WT,
    OP_F_W1,
    OP_F_W2,
    OP_F_W3,
    OP_F_W4,
    OP_EMIT
  } op_e;

  typedef struct packed {
    op_e  op;
    logic tail;    // free walk places the shrink tail instead of the request block
  } cmd_t;

  typedef struct packed {
    logic ready;
    req_e typ;
    logic n_zero;
    logic p_zero;
    logic too_big;
    logic addr_ok;
    logic walk_a;
    logic fit;
    logic split;
    logic walk_f;
    logic shrink;
    logic tail_ok;
    logic out_free;
  } stat_t;

endpackage

/* sv/ffca_if.sv */
// Handshake channels of the allocator: request, response and register write.
// Depends on ffca_pkg for the register port widths.
interface ffca_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] size_bytes;
  logic [31:0] block_addr;
  modport source (output valid, req_type, size_bytes, block_addr, input ready);
  modport sink (input valid, req_type, size_bytes, block_addr, output ready);
endinterface

interface ffca_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_addr;
  logic [1:0]  status;
  logic [31:0] copy_source;
  logic [31:0] copy_bytes;
  modport source (output valid, result_addr, status, copy_source, copy_bytes, input ready);
  modport sink (input valid, result_addr, status, copy_source, copy_bytes, output ready);
endinterface

interface ffca_cfg_if import ffca_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/ffca_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ffca_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/ffca_ctrl.sv */
// Sequencer of the allocator: walks the request through set-up, list walks and merges.
// Depends on ffca_pkg; drives the datapath only through cmd_t and reads stat_t.
module ffca_ctrl import ffca_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   grow;

  // a resize that had to move the block frees the old one afterwards
  assign grow = (stat_i.typ == REQ_RESIZE) && !stat_i.p_zero;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '{op: OP_NONE, tail: 1'b0};
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_ACCEPT;
          state_d  = S_START;
        end
      end
      S_START: begin
        if (stat_i.typ == REQ_NOP) state_d = S_RESP;
        else if (!stat_i.ready)    state_d = S_SETUP;
        else                       state_d = S_DISP;
      end
      S_SETUP: begin
        cmd_o.op = OP_SETUP;
        state_d  = S_DISP;
      end
      S_DISP: begin
        cmd_o.op = OP_DISP;
        case (stat_i.typ)
          REQ_ALLOC: begin
            state_d = (stat_i.n_zero || stat_i.too_big) ? S_RESP : S_A_RD;
          end
          REQ_FREE: begin
            state_d = (!stat_i.p_zero && stat_i.addr_ok) ? S_F_RD : S_RESP;
          end
          REQ_RESIZE: begin
            if (stat_i.p_zero) begin
              state_d = (stat_i.n_zero || stat_i.too_big) ? S_RESP : S_A_RD;
            end else if (stat_i.n_zero) begin
              state_d = stat_i.addr_ok ? S_F_RD : S_RESP;
            end else if (stat_i.too_big || !stat_i.addr_ok) begin
              state_d = S_RESP;
            end else begin
              state_d = S_R_RD;
            end
          end
          default: state_d = S_RESP;
        endcase
      end
      S_A_RD: begin
        cmd_o.op = OP_A_RD;
        state_d  = stat_i.walk_a ? S_A_CHK : S_RESP;
      end
      S_A_CHK: begin
        cmd_o.op = OP_A_CHK;
        if (!stat_i.fit)      state_d = S_A_RD;
        else if (stat_i.split) state_d = S_A_FIN;
        else if (grow)        state_d = S_F_INIT;
        else                  state_d = S_RESP;
      end
      S_A_FIN: begin
        cmd_o.op = OP_A_FIN;
        state_d  = grow ? S_F_INIT : S_RESP;
      end
      S_R_RD: begin
        cmd_o.op = OP_R_RD;
        state_d  = S_R_CHK;
      end
      S_R_CHK: begin
        cmd_o.op = OP_R_CHK;
        state_d  = S_R_DEC;
      end
      S_R_DEC: begin
        cmd_o.op = OP_R_DEC;
        if (stat_i.shrink) state_d = stat_i.tail_ok ? S_R_SHR2 : S_RESP;
        else               state_d = S_A_RD;
      end
      S_R_SHR2: begin
        cmd_o.op = OP_R_SHR2;
        state_d  = S_F_INIT;
      end
      S_F_INIT: begin
        cmd_o.op   = OP_F_INIT;
        cmd_o.tail = (stat_i.typ == REQ_RESIZE) && stat_i.shrink;
        state_d    = S_F_RD;
      end
      S_F_RD: begin
        cmd_o.op = OP_F_RD;
        state_d  = stat_i.walk_f ? S_F_WT : S_F_W1;
      end
      S_F_WT: begin
        cmd_o.op = OP_F_WT;
        state_d  = S_F_RD;
      end
      S_F_W1: begin
        cmd_o.op = OP_F_W1;
        state_d  = S_F_W2;
      end
      S_F_W2: begin
        cmd_o.op = OP_F_W2;
        state_d  = S_F_W3;
      end
      S_F_W3: begin
        cmd_o.op = OP_F_W3;
        state_d  = S_F_W4;
      end
      S_F_W4: begin
        cmd_o.op = OP_F_W4;
        state_d  = S_RESP;
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

/* sv/ffca_dpath.sv */
// Datapath of the allocator: registers, block size and next-free memories, result register.
// Depends on ffca_pkg and ffca_ram; acts on the cmd_t of ffca_ctrl.
module ffca_dpath import ffca_pkg::*; #(
  parameter int unsigned ARENA_GRANULES = 65536
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output stat_t                 stat_o,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [1:0]            req_type_i,
  input  logic [31:0]           size_bytes_i,
  input  logic [31:0]           block_addr_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [31:0]           result_addr_o,
  output logic [1:0]            status_o,
  output logic [31:0]           copy_source_o,
  output logic [31:0]           copy_bytes_o
);

  localparam int unsigned IW  = $clog2(ARENA_GRANULES + 1);
  localparam int unsigned AW  = $clog2(ARENA_GRANULES);
  localparam int unsigned STW = IW + 1;
  localparam logic [IW-1:0] NONE_IDX = IW'(ARENA_GRANULES);

  function automatic logic [IW-1:0] norm(input logic [IW-1:0] v, input logic [IW-1:0] g);
    return (v < g) ? v : NONE_IDX;
  endfunction

  // config and arena control
  logic [31:0]           cfg_base_q;
  logic [CFG_DATA_W-1:0] cfg_end_q;
  logic                  ready_q, ready_d;
  logic [IW-1:0]         head_q, head_d;
  logic                  out_valid_q, out_valid_d;
  // latched arena
  logic [31:0]           base_q, base_d;
  logic [32:0]           end_q, end_d;
  logic [IW-1:0]         gran_q, gran_d;
  // request
  req_e                  typ_q, typ_d;
  logic [31:0]           n_q, n_d, p_q, p_d;
  // walk state
  logic [IW-1:0]         cur_q, cur_d, prev_q, prev_d, fh_q, fh_d;
  logic [STW-1:0]        steps_q, steps_d;
  logic [IW-1:0]         sh_q, sh_d, ncur_q, ncur_d, nh_q, nh_d, old_q, old_d;
  // result and output
  logic [31:0]           res_addr_q, res_addr_d, res_src_q, res_src_d, res_cnt_q, res_cnt_d;
  status_e               res_st_q, res_st_d;
  logic [31:0]           out_addr_q, out_addr_d, out_src_q, out_src_d, out_cnt_q, out_cnt_d;
  status_e               out_st_q, out_st_d;

  // memory ports
  logic          s_we, n_we;
  logic [AW-1:0] s_wa, s_ra, n_wa, n_ra;
  logic [IW-1:0] s_wd, n_wd, rs, rn;

  ffca_ram #(.WIDTH(IW), .DEPTH(ARENA_GRANULES)) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_wa),
    .wdata_i (s_wd),
    .raddr_i (s_ra),
    .rdata_o (rs)
  );

  ffca_ram #(.WIDTH(IW), .DEPTH(ARENA_GRANULES)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (n_we),
    .waddr_i (n_wa),
    .wdata_i (n_wd),
    .raddr_i (n_ra),
    .rdata_o (rn)
  );

  // arena set-up from the registers
  logic [32:0]       base_m33, span;
  logic [NEED_W-1:0] g_raw;
  logic [IW-1:0]     gran_new;
  assign base_m33 = {1'b0, cfg_base_q[31:4], 4'b0000};
  assign span     = cfg_end_q - base_m33;
  assign g_raw    = span[32:4];
  assign gran_new = (cfg_end_q > base_m33) ?
                    ((g_raw > NEED_W'(ARENA_GRANULES)) ? NONE_IDX : g_raw[IW-1:0]) : '0;

  // request decode
  logic [32:0]       n15, p33, b33, off;
  logic [NEED_W-1:0] need, idx_w;
  logic [IW-1:0]     h_idx;
  logic              addr_ok;
  assign n15     = {1'b0, n_q} + 33'd15;
  assign need    = n15[32:4] + NEED_W'(1);
  assign p33     = {1'b0, p_q};
  assign b33     = {1'b0, base_q};
  assign off     = p33 - b33;
  assign idx_w   = off[32:4] - NEED_W'(1);
  assign h_idx   = idx_w[IW-1:0];
  assign addr_ok = (p_q[3:0] == 4'd0) && (p33 >= b33 + 33'd16) && (idx_w < NEED_W'(gran_q));

  // allocation walk
  logic [NEED_W-1:0] rem, nf;
  logic [IW-1:0]     nx;
  logic              fit, split, walk_a, walk_f, cur_blk, prev_blk;
  assign cur_blk  = cur_q < gran_q;
  assign prev_blk = prev_q < gran_q;
  assign nx       = norm(rn, gran_q);
  assign fit      = NEED_W'(rs) >= need;
  assign rem      = NEED_W'(rs) - need;
  assign nf       = NEED_W'(cur_q) + need;
  assign split    = (rem >= NEED_W'(MIN_SPLIT_GRAN)) && (nf < NEED_W'(gran_q));
  assign walk_a   = cur_blk && (steps_q <= {1'b0, gran_q});
  assign walk_f   = cur_blk && (cur_q < fh_q) && (steps_q <= {1'b0, gran_q});

  // resize in place
  logic [NEED_W-1:0] trem, t;
  logic              shrink, tail_ok;
  assign shrink  = need <= NEED_W'(old_q);
  assign trem    = NEED_W'(old_q) - need;
  assign t       = NEED_W'(h_idx) + need;
  assign tail_ok = (trem >= NEED_W'(MIN_SPLIT_GRAN)) && (t < NEED_W'(gran_q));

  // merges
  logic merge_r, merge_l;
  assign merge_r = cur_blk && (({1'b0, fh_q} + {1'b0, sh_q}) == {1'b0, cur_q});
  assign merge_l = prev_blk && (({1'b0, prev_q} + {1'b0, rs}) == {1'b0, fh_q});

  logic [31:0] pay, copy_cnt;
  assign pay      = base_q + ((32'(cur_q) + 32'd1) << 4);
  assign copy_cnt = (old_q != '0) ? ((32'(old_q) - 32'd1) << 4) : 32'd0;

  always_comb begin
    stat_o.ready    = ready_q;
    stat_o.typ      = typ_q;
    stat_o.n_zero   = n_q == 32'd0;
    stat_o.p_zero   = p_q == 32'd0;
    stat_o.too_big  = {1'b0, n_q} > end_q;
    stat_o.addr_ok  = addr_ok;
    stat_o.walk_a   = walk_a;
    stat_o.fit      = fit;
    stat_o.split    = split;
    stat_o.walk_f   = walk_f;
    stat_o.shrink   = shrink;
    stat_o.tail_ok  = tail_ok;
    stat_o.out_free = !out_valid_q || out_ready_i;
  end

  always_comb begin
    ready_d     = ready_q;
    head_d      = head_q;
    out_valid_d = out_valid_q && !out_ready_i;
    base_d      = base_q;
    end_d       = end_q;
    gran_d      = gran_q;
    typ_d       = typ_q;
    n_d         = n_q;
    p_d         = p_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    fh_d        = fh_q;
    steps_d     = steps_q;
    sh_d        = sh_q;
    ncur_d      = ncur_q;
    nh_d        = nh_q;
    old_d       = old_q;
    res_addr_d  = res_addr_q;
    res_st_d    = res_st_q;
    res_src_d   = res_src_q;
    res_cnt_d   = res_cnt_q;
    out_addr_d  = out_addr_q;
    out_st_d    = out_st_q;
    out_src_d   = out_src_q;
    out_cnt_d   = out_cnt_q;
    s_we        = 1'b0;
    s_wa        = cur_q[AW-1:0];
    s_wd        = need[IW-1:0];
    s_ra        = cur_q[AW-1:0];
    n_we        = 1'b0;
    n_wa        = prev_q[AW-1:0];
    n_wd        = nx;
    n_ra        = cur_q[AW-1:0];
    case (cmd_i.op)
      OP_ACCEPT: begin
        typ_d      = req_e'(req_type_i);
        n_d        = size_bytes_i;
        p_d        = block_addr_i;
        res_addr_d = '0;
        res_st_d   = ST_DONE;
        res_src_d  = '0;
        res_cnt_d  = '0;
      end
      OP_SETUP: begin
        ready_d = 1'b1;
        base_d  = base_m33[31:0];
        end_d   = cfg_end_q;
        gran_d  = gran_new;
        head_d  = NONE_IDX;
        if (gran_new != '0) begin
          head_d = '0;
          s_we   = 1'b1;
          s_wa   = '0;
          s_wd   = gran_new;
          n_we   = 1'b1;
          n_wa   = '0;
          n_wd   = NONE_IDX;
        end
      end
      OP_DISP: begin
        cur_d   = head_q;
        prev_d  = NONE_IDX;
        steps_d = '0;
        fh_d    = h_idx;
        case (typ_q)
          REQ_ALLOC: begin
            if (n_q == 32'd0)             res_st_d = ST_NULL;
            else if ({1'b0, n_q} > end_q) res_st_d = ST_FAIL;
          end
          REQ_FREE: begin
            if (p_q == 32'd0) res_st_d = ST_NULL;
          end
          REQ_RESIZE: begin
            if (p_q == 32'd0) begin
              if (n_q == 32'd0)             res_st_d = ST_NULL;
              else if ({1'b0, n_q} > end_q) res_st_d = ST_FAIL;
            end else if (n_q == 32'd0) begin
              res_st_d = ST_NULL;
            end else if (({1'b0, n_q} > end_q) || !addr_ok) begin
              res_st_d = ST_FAIL;
            end
          end
          default: ;
        endcase
      end
      OP_A_RD: begin
        if (!walk_a) res_st_d = ST_FAIL;
      end
      OP_A_CHK: begin
        if (fit) begin
          res_addr_d = pay;
          if ((typ_q == REQ_RESIZE) && (p_q != 32'd0)) begin
            res_src_d = p_q;
            res_cnt_d = copy_cnt;
          end
          if (split) begin
            s_we = 1'b1;
            s_wa = nf[AW-1:0];
            s_wd = rem[IW-1:0];
            n_we = 1'b1;
            n_wa = nf[AW-1:0];
            n_wd = nx;
          end else if (prev_blk) begin
            n_we = 1'b1;
          end else begin
            head_d = nx;
          end
        end else begin
          prev_d  = cur_q;
          cur_d   = nx;
          steps_d = steps_q + STW'(1);
        end
      end
      OP_A_FIN: begin
        s_we = 1'b1;
        n_wd = nf[IW-1:0];
        if (prev_blk) n_we = 1'b1;
        else          head_d = nf[IW-1:0];
      end
      OP_R_RD: begin
        s_ra = h_idx[AW-1:0];
      end
      OP_R_CHK: begin
        old_d = rs;
      end
      OP_R_DEC: begin
        if (shrink) begin
          res_addr_d = p_q;
          if (tail_ok) begin
            s_we = 1'b1;
            s_wa = h_idx[AW-1:0];
          end
        end
      end
      OP_R_SHR2: begin
        s_we = 1'b1;
        s_wa = t[AW-1:0];
        s_wd = trem[IW-1:0];
      end
      OP_F_INIT: begin
        cur_d   = head_q;
        prev_d  = NONE_IDX;
        steps_d = '0;
        fh_d    = cmd_i.tail ? t[IW-1:0] : h_idx;
      end
      OP_F_RD: ;
      OP_F_WT: begin
        prev_d  = cur_q;
        cur_d   = nx;
        steps_d = steps_q + STW'(1);
      end
      OP_F_W1: begin
        n_we = 1'b1;
        n_wa = fh_q[AW-1:0];
        n_wd = cur_q;
        s_ra = fh_q[AW-1:0];
      end
      OP_F_W2: begin
        // link the freed block behind its predecessor
        n_wd   = fh_q;
        if (prev_blk) n_we = 1'b1;
        else          head_d = fh_q;
        sh_d   = rs;
        ncur_d = nx;
        nh_d   = cur_q;
      end
      OP_F_W3: begin
        s_ra = prev_q[AW-1:0];
        if (merge_r) begin
          s_we = 1'b1;
          s_wa = fh_q[AW-1:0];
          s_wd = sh_q + rs;
          n_we = 1'b1;
          n_wa = fh_q[AW-1:0];
          n_wd = ncur_q;
          sh_d = sh_q + rs;
          nh_d = ncur_q;
        end
      end
      OP_F_W4: begin
        if (merge_l) begin
          s_we = 1'b1;
          s_wa = prev_q[AW-1:0];
          s_wd = rs + sh_q;
          n_we = 1'b1;
          n_wd = nh_q;
        end
      end
      OP_EMIT: begin
        out_valid_d = 1'b1;
        out_addr_d  = res_addr_q;
        out_st_d    = res_st_q;
        out_src_d   = res_src_q;
        out_cnt_d   = res_cnt_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_base_q  <= '0;
      cfg_end_q   <= ARENA_END_RST;
      ready_q     <= 1'b0;
      head_q      <= NONE_IDX;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_ARENA_BASE: cfg_base_q <= cfg_data_i[31:0];
          CFG_ARENA_END:  cfg_end_q  <= cfg_data_i;
          default: ;
        endcase
      end
      ready_q     <= ready_d;
      head_q      <= head_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q     <= base_d;
    end_q      <= end_d;
    gran_q     <= gran_d;
    typ_q      <= typ_d;
    n_q        <= n_d;
    p_q        <= p_d;
    cur_q      <= cur_d;
    prev_q     <= prev_d;
    fh_q       <= fh_d;
    steps_q    <= steps_d;
    sh_q       <= sh_d;
    ncur_q     <= ncur_d;
    nh_q       <= nh_d;
    old_q      <= old_d;
    res_addr_q <= res_addr_d;
    res_st_q   <= res_st_d;
    res_src_q  <= res_src_d;
    res_cnt_q  <= res_cnt_d;
    out_addr_q <= out_addr_d;
    out_st_q   <= out_st_d;
    out_src_q  <= out_src_d;
    out_cnt_q  <= out_cnt_d;
  end

  assign out_valid_o   = out_valid_q;
  assign result_addr_o = out_addr_q;
  assign status_o      = out_st_q;
  assign copy_source_o = out_src_q;
  assign copy_bytes_o  = out_cnt_q;

endmodule

/* sv/first_fit_coalescing_allocator_unit.sv */
// First-fit coalescing heap allocator, top level: sequencer plus datapath with two memories.
// A no-op goes straight from the start state to the response; every other request is
// dispatched, after an arena set-up step for the first such request. An allocate reads and
// checks each free list entry in turn, with a final step when it splits; a free walks
// the list to the block's place, then links and merges it. Each walk step waits on one
// registered memory read. One request is in flight at a time; the next is taken while the
// result waits in the output register. Reset clears control state only; the arena is set
// up by the first request that is not a no-op.
module first_fit_coalescing_allocator_unit import ffca_pkg::*; #(
  parameter int unsigned ARENA_GRANULES = 65536
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ffca_cfg_if.sink   cfg_i,
  ffca_req_if.sink   req_i,
  ffca_rsp_if.source rsp_o
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_i.ready = 1'b1;

  ffca_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ffca_dpath #(.ARENA_GRANULES(ARENA_GRANULES)) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_valid_i   (cfg_i.valid),
    .cfg_index_i   (cfg_i.index),
    .cfg_data_i    (cfg_i.data),
    .req_type_i    (req_i.req_type),
    .size_bytes_i  (req_i.size_bytes),
    .block_addr_i  (req_i.block_addr),
    .out_valid_o   (rsp_o.valid),
    .out_ready_i   (rsp_o.ready),
    .result_addr_o (rsp_o.result_addr),
    .status_o      (rsp_o.status),
    .copy_source_o (rsp_o.copy_source),
    .copy_bytes_o  (rsp_o.copy_bytes)
  );

  // a transfer in leaves the idle state at once
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request port still ready after a transfer");

  // a new result only appears after the block was busy
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(!req_i.ready))
    else $error("result appeared while idle");

  // any non-done status carries a null address and no copy
  a_null_on_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.status != ST_DONE) |->
      (rsp_o.result_addr == 32'd0) && (rsp_o.copy_source == 32'd0))
    else $error("rejected request returned an address");

endmodule

/* bench/ffca_checker.sv */
// Scoreboard for the first-fit coalescing allocator: watches the register, request and
// response channels, predicts each result and compares it. Depends on ffca_pkg, ffca_if.
module ffca_checker import ffca_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ffca_cfg_if         cfg,
  ffca_req_if         req,
  ffca_rsp_if         rsp,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o
);

  localparam longint unsigned NGRAN = 65536;
  localparam longint unsigned NO_BLK = 65536;
  localparam longint unsigned SZ_MASK = 2 * NGRAN - 1;

  typedef struct packed {
    logic [31:0] addr;
    status_e     status;
    logic [31:0] src;
    logic [31:0] len;
  } alloc_result_t;

  int unsigned     blk_size[65536];
  int unsigned     blk_next[65536];
  longint unsigned head;
  bit              armed;
  logic [31:0]     reg_base;
  logic [32:0]     reg_end;
  longint unsigned lat_base, lat_end, gran;
  alloc_result_t   reply_q[$];

  assign pending_o = reply_q.size();

  function automatic bit in_arena(longint unsigned i);
    return i < gran;
  endfunction

  function automatic longint unsigned size_at(longint unsigned i);
    return in_arena(i) ? blk_size[i] : 0;
  endfunction

  function automatic void set_size(longint unsigned i, longint unsigned v);
    if (in_arena(i)) blk_size[i] = v & SZ_MASK;
  endfunction

  function automatic longint unsigned next_at(longint unsigned i);
    if (!in_arena(i)) return NO_BLK;
    return in_arena(blk_next[i]) ? blk_next[i] : NO_BLK;
  endfunction

  function automatic void set_next(longint unsigned i, longint unsigned v);
    if (in_arena(i)) blk_next[i] = in_arena(v) ? v : NO_BLK;
  endfunction

  function automatic void link(longint unsigned prev, longint unsigned v);
    if (in_arena(prev)) set_next(prev, v);
    else head = in_arena(v) ? v : NO_BLK;
  endfunction

  function automatic void arm_arena();
    longint unsigned g;
    g = 0;
    lat_base = reg_base & 32'hFFFF_FFF0;
    lat_end = reg_end;
    if (lat_end > lat_base) begin
      g = (lat_end - lat_base) >> 4;
      if (g > NGRAN) g = NGRAN;
    end
    gran = g;
    head = NO_BLK;
    if (gran > 0) begin
      set_size(0, gran);
      set_next(0, NO_BLK);
      head = 0;
    end
    armed = 1;
  endfunction

  function automatic bit first_fit(longint unsigned need, output longint unsigned idx);
    longint unsigned prev, cur, steps, sz, rem, nf;
    prev = NO_BLK;
    cur = head;
    steps = 0;
    idx = 0;
    while (in_arena(cur) && steps <= gran) begin
      sz = size_at(cur);
      if (sz >= need) begin
        rem = sz - need;
        nf = cur + need;
        if (rem >= MIN_SPLIT_GRAN && in_arena(nf)) begin
          set_size(nf, rem);
          set_next(nf, next_at(cur));
          set_size(cur, need);
          link(prev, nf);
        end else begin
          link(prev, next_at(cur));
        end
        idx = cur;
        return 1;
      end
      prev = cur;
      cur = next_at(cur);
      steps++;
    end
    return 0;
  endfunction

  // insert in address order, then merge right, then left
  function automatic void release_blk(longint unsigned h);
    longint unsigned prev, cur, steps;
    prev = NO_BLK;
    cur = head;
    steps = 0;
    while (in_arena(cur) && cur < h && steps <= gran) begin
      prev = cur;
      cur = next_at(cur);
      steps++;
    end
    set_next(h, cur);
    link(prev, h);
    if (in_arena(cur) && h + size_at(h) == cur) begin
      set_size(h, size_at(h) + size_at(cur));
      set_next(h, next_at(cur));
    end
    if (in_arena(prev) && prev + size_at(prev) == h) begin
      set_size(prev, size_at(prev) + size_at(h));
      set_next(prev, next_at(h));
    end
  endfunction

  function automatic bit block_of(logic [31:0] p, output longint unsigned h);
    longint unsigned i;
    h = 0;
    if (p[3:0] != 0 || longint'(p) < lat_base + 16) return 0;
    i = ((longint'(p) - lat_base) >> 4) - 1;
    if (!in_arena(i)) return 0;
    h = i;
    return 1;
  endfunction

  function automatic longint unsigned granules_for(logic [31:0] n);
    return ((longint'(n) + 15) >> 4) + 1;
  endfunction

  function automatic logic [31:0] payload_addr(longint unsigned idx);
    longint unsigned a;
    a = lat_base + 16 * (idx + 1);
    return a[31:0];
  endfunction

  function automatic alloc_result_t try_alloc(logic [31:0] n);
    alloc_result_t r;
    longint unsigned idx;
    r = '0;
    if (n == 0) r.status = ST_NULL;
    else if (longint'(n) > lat_end || !first_fit(granules_for(n), idx)) r.status = ST_FAIL;
    else r.addr = payload_addr(idx);
    return r;
  endfunction

  function automatic alloc_result_t allocator_step(logic [1:0] kind, logic [31:0] n,
                                                   logic [31:0] p);
    alloc_result_t r;
    longint unsigned h, idx, need, old, rem, t;
    r = '0;
    if (req_e'(kind) == REQ_NOP) return r;
    if (!armed) arm_arena();
    case (req_e'(kind))
      REQ_ALLOC: r = try_alloc(n);
      REQ_FREE: begin
        if (p == 0) r.status = ST_NULL;
        else if (block_of(p, h)) release_blk(h);
      end
      default: begin
        if (p == 0) return try_alloc(n);
        if (n == 0) begin
          if (block_of(p, h)) release_blk(h);
          r.status = ST_NULL;
          return r;
        end
        if (longint'(n) > lat_end || !block_of(p, h)) begin
          r.status = ST_FAIL;
          return r;
        end
        need = granules_for(n);
        old = size_at(h);
        if (need <= old) begin
          // shrink in place; tail goes back to the free list only if big enough
          rem = old - need;
          t = h + need;
          if (rem >= MIN_SPLIT_GRAN && in_arena(t)) begin
            set_size(h, need);
            set_size(t, rem);
            release_blk(t);
          end
          r.addr = p;
          return r;
        end
        if (!first_fit(need, idx)) begin
          r.status = ST_FAIL;
          return r;
        end
        r.addr = payload_addr(idx);
        r.src = p;
        r.len = old >= 1 ? ((old - 1) * 16) & 32'hFFFF_FFFF : 0;
        release_blk(h);
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_result_t want;
    if (!rst_ni) begin
      foreach (blk_size[i]) begin
        blk_size[i] = 0;
        blk_next[i] = 0;
      end
      head = NO_BLK;
      armed = 0;
      reg_base = '0;
      reg_end = ARENA_END_RST;
      lat_base = 0;
      lat_end = 0;
      gran = 0;
      reply_q.delete();
      fail_cnt_o = 0;
    end else begin
      // response first: it can only belong to a request taken at an earlier edge
      if (rsp.valid && rsp.ready) begin
        if (reply_q.size() == 0) begin
          $display("%0t: unexpected result addr=%h status=%0d src=%h len=%h", $time,
                   rsp.result_addr, rsp.status, rsp.copy_source, rsp.copy_bytes);
          fail_cnt_o++;
        end else begin
          want = reply_q.pop_front();
          if (rsp.result_addr !== want.addr || rsp.status !== want.status ||
              rsp.copy_source !== want.src || rsp.copy_bytes !== want.len) begin
            $display("%0t: result mismatch expected addr=%h status=%0d src=%h len=%h",
                     $time, want.addr, want.status, want.src, want.len);
            $display("%0t:                   actual addr=%h status=%0d src=%h len=%h",
                     $time, rsp.result_addr, rsp.status, rsp.copy_source, rsp.copy_bytes);
            fail_cnt_o++;
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == CFG_ARENA_BASE) reg_base = cfg.data[31:0];
        else reg_end = cfg.data;
      end
      if (req.valid && req.ready)
        reply_q.push_back(allocator_step(req.req_type, req.size_bytes, req.block_addr));
    end
  end

endmodule

/* bench/tb.sv */
// Top of the allocator bench: clock, reset, register writes, request and response traffic.
// Depends on ffca_pkg, ffca_if, ffca_checker and the allocator top level.
module tb;
  import ffca_pkg::*;

  localparam int unsigned N_RANDOM = 1400;
  localparam int unsigned STALL_LIMIT = 20000;

  typedef struct {
    logic [31:0] addr;
    bit          owned;
  } sent_t;

  logic clk_i;
  logic rst_ni;

  ffca_cfg_if cfg_ch ();
  ffca_req_if req_ch ();
  ffca_rsp_if rsp_ch ();

  first_fit_coalescing_allocator_unit u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_ch),
    .req_i (req_ch),
    .rsp_o (rsp_ch)
  );

  int unsigned fail_cnt, pending;

  ffca_checker u_chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg       (cfg_ch),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .fail_cnt_o(fail_cnt),
    .pending_o (pending)
  );

  logic [31:0] held_q[$];   // payload addresses currently owned by the bench
  sent_t       sent_q[$];
  logic [31:0] base_al;
  logic [32:0] end_cfg;
  int unsigned gran_cnt;
  int unsigned sent, got, oom_cnt, grow_cnt;
  bit          calm, hold_go, hold_done;
  int unsigned hold_cnt, gap, stall;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // response side: random stall bursts, one long hold-off, none near the end
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 0;
      gap <= 0;
      hold_cnt <= 0;
      hold_done <= 0;
    end else if (hold_go && !hold_done) begin
      rsp_ch.ready <= 0;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt == 400) hold_done <= 1;
    end else if (gap != 0) begin
      gap <= gap - 1;
      rsp_ch.ready <= (gap == 1);
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      gap <= $urandom_range(1, 17);
      rsp_ch.ready <= 0;
    end else begin
      rsp_ch.ready <= 1;
    end
  end

  // track owned blocks from returned results; a failed resize keeps the old block
  always @(negedge clk_i) begin
    sent_t s;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready && sent_q.size() != 0) begin
      s = sent_q.pop_front();
      got++;
      if (rsp_ch.result_addr != 0) held_q.push_back(rsp_ch.result_addr);
      else if (s.owned && status_e'(rsp_ch.status) == ST_FAIL) held_q.push_back(s.addr);
      if (status_e'(rsp_ch.status) == ST_FAIL) oom_cnt++;
      if (rsp_ch.copy_source != 0) grow_cnt++;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        stall <= 0;
      end else if (stall == STALL_LIMIT) begin
        $display("first_fit_coalescing_allocator_unit verification failed");
        $finish;
      end else begin
        stall <= stall + 1;
      end
    end
  end

  task automatic offer(input req_e kind, input logic [31:0] n, input logic [31:0] p,
                       input bit owned);
    sent_t s;
    req_ch.valid <= 1;
    req_ch.req_type <= kind;
    req_ch.size_bytes <= n;
    req_ch.block_addr <= p;
    do @(posedge clk_i); while (!req_ch.ready);
    s.addr = p;
    s.owned = owned;
    sent_q.push_back(s);
    sent++;
    if (sent == 300) hold_go <= 1;
    if (!calm && $urandom_range(0, 7) == 0) begin
      req_ch.valid <= 0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx;
    cfg_ch.data <= v;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    req_ch.valid <= 0;
    // the checker books the last transfer at its edge, so look only after that edge
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [31:0] take_held();
    int unsigned k;
    logic [31:0] a;
    k = $urandom_range(0, held_q.size() - 1);
    a = held_q[k];
    held_q.delete(k);
    return a;
  endfunction

  // addresses the block must reject: unaligned, at the arena base, past the arena
  function automatic logic [31:0] bad_addr();
    case ($urandom_range(0, 2))
      0: return $urandom | 32'h1;
      1: return base_al;
      default: return base_al + 16 * (gran_cnt + 1 + $urandom_range(0, 1000));
    endcase
  endfunction

  function automatic logic [31:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 256);
    if (r < 95) return $urandom_range(257, 2048);
    return $urandom;
  endfunction

  task automatic random_item();
    int unsigned r;
    logic [31:0] a;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      offer(REQ_ALLOC, pick_size(), $urandom, 0);
    end else if (r < 60) begin
      if (held_q.size() != 0) offer(REQ_FREE, $urandom, take_held(), 0);
      else offer(REQ_FREE, $urandom, bad_addr(), 0);
    end else if (r < 88) begin
      if (held_q.size() != 0) begin
        a = take_held();
        offer(REQ_RESIZE, $urandom_range(0, 4) == 0 ? 32'd0 : pick_size(), a, 1);
      end else begin
        offer(REQ_RESIZE, pick_size(), 32'd0, 0);
      end
    end else begin
      case ($urandom_range(0, 5))
        0: offer(REQ_NOP, $urandom, $urandom, 0);
        1: offer(REQ_FREE, $urandom, 32'd0, 0);
        2: offer(REQ_FREE, $urandom, bad_addr(), 0);
        3: offer(REQ_RESIZE, pick_size() | 32'h1, bad_addr(), 0);
        4: offer(REQ_ALLOC, 32'd0, $urandom, 0);
        default: offer(REQ_ALLOC, 32'hF000_0000 | $urandom, 32'd0, 0);
      endcase
    end
  endtask

  initial begin
    logic [31:0] base_cfg;
    logic [31:0] a;
    rst_ni = 0;
    calm = 0;
    hold_go = 0;
    sent = 0;
    got = 0;
    oom_cnt = 0;
    grow_cnt = 0;
    cfg_ch.valid = 0;
    cfg_ch.index = CFG_ARENA_BASE;
    cfg_ch.data = '0;
    req_ch.valid = 0;
    req_ch.req_type = REQ_NOP;
    req_ch.size_bytes = '0;
    req_ch.block_addr = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // small arena so that out-of-memory and coalescing come up often
    base_cfg = $urandom & 32'hEFFF_FFFF;
    base_al = base_cfg & 32'hFFFF_FFF0;
    gran_cnt = $urandom_range(160, 400);
    end_cfg = {1'b0, base_al} + 16 * gran_cnt + $urandom_range(0, 15);
    write_reg(CFG_ARENA_BASE, {1'b0, base_cfg});
    write_reg(CFG_ARENA_END, end_cfg);

    offer(REQ_ALLOC, 32'd0, 32'd0, 0);
    offer(REQ_ALLOC, 32'd1, 32'd0, 0);
    offer(REQ_ALLOC, 32'd16, 32'd0, 0);
    offer(REQ_ALLOC, 32'd17, 32'd0, 0);
    offer(REQ_ALLOC, 32'hFFFF_FFFF, 32'd0, 0);
    offer(REQ_ALLOC, end_cfg[31:0], 32'd0, 0);
    offer(REQ_FREE, 32'd0, 32'd0, 0);
    offer(REQ_FREE, 32'd0, 32'hFFFF_FFFF, 0);
    offer(REQ_FREE, 32'd0, base_al, 0);
    offer(REQ_RESIZE, 32'd40, 32'd0, 0);
    offer(REQ_RESIZE, 32'd0, 32'd0, 0);
    offer(REQ_RESIZE, 32'd5, bad_addr(), 0);
    offer(REQ_RESIZE, 32'hFFFF_FFFF, base_al + 32'd16, 0);
    offer(REQ_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    offer(REQ_ALLOC, 32'd100, 32'd0, 0);
    offer(REQ_ALLOC, 32'd200, 32'd0, 0);
    drain();
    // shrink, grow, resize to zero and free on owned blocks
    if (held_q.size() != 0) offer(REQ_RESIZE, 32'd1, take_held(), 1);
    if (held_q.size() != 0) offer(REQ_RESIZE, 32'd2000, take_held(), 1);
    if (held_q.size() != 0) offer(REQ_RESIZE, 32'd0, take_held(), 1);
    drain();
    while (held_q.size() != 0) begin
      a = take_held();
      offer(REQ_FREE, 32'd0, a, 0);
    end
    drain();

    // later register writes only take effect after a reset; they must not disturb the heap
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 2) calm = 1;
      for (int unsigned i = 0; i < N_RANDOM / 3; i++) random_item();
      drain();
      case (ph)
        0: begin
          write_reg(CFG_ARENA_BASE, 33'h0_FFFF_FFFF);
          write_reg(CFG_ARENA_END, 33'h1_0000_0000);
        end
        1: begin
          write_reg(CFG_ARENA_BASE, '0);
          write_reg(CFG_ARENA_END, 33'd16);
        end
        default: ;
      endcase
    end

    repeat (50) @(posedge clk_i);
    $display("run: %0d requests, %0d results, %0d refusals, %0d growths with copy",
             sent, got, oom_cnt, grow_cnt);
    $display("arena of %0d granules at %h, with stalls and a long response hold-off",
             gran_cnt, base_al);
    if (fail_cnt == 0) begin
      $display("first_fit_coalescing_allocator_unit verification clean");
    end else begin
      $display("first_fit_coalescing_allocator_unit verification failed");
    end
    $finish;
  end

endmodule
